// ----- hdl/owbpe_pkg.sv -----
// Shared types, constants and helpers for the one-wire backlight pulse encoder.
// Depends on nothing; used by the controller, the datapath and the top level.
package owbpe_pkg;

  // Field and port widths.
  localparam int LEVEL_W    = 8;
  localparam int HOLD_W     = 18;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 11;
  localparam int BIT_IDX_W  = 3;
  localparam int S_TDATA_W  = 8;
  localparam int M_TDATA_W  = 24;

  // Default bit counts of the two frames.
  localparam int ADDR_BITS_DEF = 8;
  localparam int DATA_BITS_DEF = 8;

  // Fixed segment times in microseconds.
  localparam logic [HOLD_W-1:0] WAIT_US     = 18'd200000;
  localparam logic [HOLD_W-1:0] SHUTDOWN_US = 18'd5000;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ADDRESS = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_US       = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_US        = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_US       = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_EOS_US         = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ES_DELAY_US    = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ES_DETECT_US   = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_ES_WINDOW_US   = 4'd7;

  // Kind of line segment the controller asks the datapath to emit.
  typedef enum logic [3:0] {
    SEG_WAIT,
    SEG_SHUT,
    SEG_DELAY,
    SEG_DETECT,
    SEG_WINDOW,
    SEG_START,
    SEG_BIT_LO,
    SEG_BIT_HI,
    SEG_EOS,
    SEG_FINAL
  } seg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                 load;        // request accepted, capture the level
    logic                 emit;        // load one segment into the output register
    seg_t                 seg;         // which segment
    logic                 frame_data;  // 0: address frame, 1: data frame
    logic [BIT_IDX_W-1:0] bit_idx;     // bit of the frame being sent
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;    // output register can take a segment this cycle
    logic prev_zero;   // previous request was level zero
    logic level_zero;  // current request is level zero
    logic enabled;     // device has seen the enable preamble
  } status_t;

  // A timing value of zero is stretched to one microsecond.
  function automatic logic [HOLD_W-1:0] at_least_one(input logic [CFG_DATA_W-1:0] v);
    logic [HOLD_W-1:0] r;
    r = HOLD_W'(v);
    if (v == '0) begin
      r = HOLD_W'(1);
    end
    return r;
  endfunction

endpackage

// ----- hdl/owbpe_ctrl.sv -----
// Sequencing controller for the one-wire backlight pulse encoder.
// Depends on owbpe_pkg; drives commands into owbpe_datapath.
module owbpe_ctrl #(
  parameter int ADDR_BITS = owbpe_pkg::ADDR_BITS_DEF,
  parameter int DATA_BITS = owbpe_pkg::DATA_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  owbpe_pkg::status_t status,
  output owbpe_pkg::cmd_t    cmd
);
  import owbpe_pkg::*;

  typedef enum logic [10:0] {
    ST_IDLE   = 11'b000_0000_0001,
    ST_HEAD   = 11'b000_0000_0010,
    ST_SHUT   = 11'b000_0000_0100,
    ST_DELAY  = 11'b000_0000_1000,
    ST_DETECT = 11'b000_0001_0000,
    ST_WINDOW = 11'b000_0010_0000,
    ST_START  = 11'b000_0100_0000,
    ST_BIT_LO = 11'b000_1000_0000,
    ST_BIT_HI = 11'b001_0000_0000,
    ST_EOS    = 11'b010_0000_0000,
    ST_FINAL  = 11'b100_0000_0000
  } state_t;

  localparam logic [BIT_IDX_W-1:0] ADDR_TOP = BIT_IDX_W'(ADDR_BITS - 1);
  localparam logic [BIT_IDX_W-1:0] DATA_TOP = BIT_IDX_W'(DATA_BITS - 1);

  state_t               state, state_next;
  logic [BIT_IDX_W-1:0] bit_cnt, bit_cnt_next;
  logic                 frame, frame_next;
  logic                 accept;
  logic                 step;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign step     = status.out_free;

  // Next state and segment selection.
  always_comb begin
    state_next     = state;
    bit_cnt_next   = bit_cnt;
    frame_next     = frame;
    cmd.load       = accept;
    cmd.emit       = 1'b0;
    cmd.seg        = SEG_WAIT;
    cmd.frame_data = frame;
    cmd.bit_idx    = bit_cnt;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next   = ST_HEAD;
          frame_next   = 1'b0;
          bit_cnt_next = ADDR_TOP;
        end
      end
      ST_HEAD: begin
        if (step) begin
          cmd.emit = status.prev_zero;
          cmd.seg  = SEG_WAIT;
          if (status.level_zero) begin
            state_next = ST_SHUT;
          end else if (status.enabled) begin
            state_next = ST_START;
          end else begin
            state_next = ST_DELAY;
          end
        end
      end
      ST_SHUT: begin
        cmd.seg = SEG_SHUT;
        if (step) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_DELAY: begin
        cmd.seg = SEG_DELAY;
        if (step) begin
          cmd.emit   = 1'b1;
          state_next = ST_DETECT;
        end
      end
      ST_DETECT: begin
        cmd.seg = SEG_DETECT;
        if (step) begin
          cmd.emit   = 1'b1;
          state_next = ST_WINDOW;
        end
      end
      ST_WINDOW: begin
        cmd.seg = SEG_WINDOW;
        if (step) begin
          cmd.emit   = 1'b1;
          state_next = ST_START;
        end
      end
      ST_START: begin
        cmd.seg = SEG_START;
        if (step) begin
          cmd.emit   = 1'b1;
          state_next = ST_BIT_LO;
        end
      end
      ST_BIT_LO: begin
        cmd.seg = SEG_BIT_LO;
        if (step) begin
          cmd.emit   = 1'b1;
          state_next = ST_BIT_HI;
        end
      end
      ST_BIT_HI: begin
        cmd.seg = SEG_BIT_HI;
        if (step) begin
          cmd.emit = 1'b1;
          if (bit_cnt == '0) begin
            state_next = ST_EOS;
          end else begin
            bit_cnt_next = bit_cnt - BIT_IDX_W'(1);
            state_next   = ST_BIT_LO;
          end
        end
      end
      ST_EOS: begin
        cmd.seg = SEG_EOS;
        if (step) begin
          cmd.emit = 1'b1;
          if (!frame) begin
            frame_next   = 1'b1;
            bit_cnt_next = DATA_TOP;
            state_next   = ST_START;
          end else begin
            state_next = ST_FINAL;
          end
        end
      end
      ST_FINAL: begin
        cmd.seg = SEG_FINAL;
        if (step) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      bit_cnt <= '0;
      frame   <= 1'b0;
    end else begin
      state   <= state_next;
      bit_cnt <= bit_cnt_next;
      frame   <= frame_next;
    end
  end

endmodule

// ----- hdl/owbpe_datapath.sv -----
// Datapath of the one-wire backlight pulse encoder: configuration registers,
// line state, segment formatting and the output register. Depends on owbpe_pkg.
module owbpe_datapath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [owbpe_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [owbpe_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic [owbpe_pkg::LEVEL_W-1:0]         level_in,
  input  owbpe_pkg::cmd_t                       cmd,
  output owbpe_pkg::status_t                    status,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  out_ctrl,
  output logic                                  out_enable,
  output logic [owbpe_pkg::HOLD_W-1:0]          out_hold,
  output logic                                  out_last
);
  import owbpe_pkg::*;

  // Configuration registers.
  logic [7:0]  device_address;
  logic [8:0]  short_us;
  logic [9:0]  long_us;
  logic [8:0]  start_us;
  logic [8:0]  eos_us;
  logic [9:0]  es_delay_us;
  logic [9:0]  es_detect_us;
  logic [10:0] es_window_us;

  // Block state.
  logic [LEVEL_W-1:0] level;
  logic               prev_zero;
  logic               enabled;
  logic               ctrl_now;
  logic               enable_now;

  // Segment being formed.
  logic              seg_ctrl;
  logic              seg_enable;
  logic [HOLD_W-1:0] seg_hold;
  logic              seg_last;
  logic              bit_val;
  logic [HOLD_W-1:0] hold_short;
  logic [HOLD_W-1:0] hold_long;

  assign cfg_ready = 1'b1;

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= 8'h72;
      short_us       <= 9'd4;
      long_us        <= 10'd8;
      start_us       <= 9'd4;
      eos_us         <= 9'd4;
      es_delay_us    <= 10'd200;
      es_detect_us   <= 10'd500;
      es_window_us   <= 11'd1000;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_DEVICE_ADDRESS: device_address <= cfg_data[7:0];
        CFG_SHORT_US:       short_us       <= cfg_data[8:0];
        CFG_LONG_US:        long_us        <= cfg_data[9:0];
        CFG_START_US:       start_us       <= cfg_data[8:0];
        CFG_EOS_US:         eos_us         <= cfg_data[8:0];
        CFG_ES_DELAY_US:    es_delay_us    <= cfg_data[9:0];
        CFG_ES_DETECT_US:   es_detect_us   <= cfg_data[9:0];
        CFG_ES_WINDOW_US:   es_window_us   <= cfg_data;
        default: ;
      endcase
    end
  end

  // The bit being sent, MSB first, from the address or the level.
  assign bit_val    = cmd.frame_data ? level[cmd.bit_idx] : device_address[cmd.bit_idx];
  assign hold_short = at_least_one(CFG_DATA_W'(short_us));
  assign hold_long  = at_least_one(CFG_DATA_W'(long_us));

  // Line levels and hold time of each segment kind.
  always_comb begin
    seg_ctrl   = 1'b0;
    seg_enable = enable_now;
    seg_hold   = hold_short;
    seg_last   = 1'b0;
    case (cmd.seg)
      SEG_WAIT: begin
        seg_ctrl = ctrl_now;
        seg_hold = WAIT_US;
      end
      SEG_SHUT: begin
        seg_enable = 1'b0;
        seg_hold   = SHUTDOWN_US;
        seg_last   = 1'b1;
      end
      SEG_DELAY: begin
        seg_ctrl   = 1'b1;
        seg_enable = 1'b1;
        seg_hold   = at_least_one(CFG_DATA_W'(es_delay_us));
      end
      SEG_DETECT: begin
        seg_enable = 1'b1;
        seg_hold   = at_least_one(CFG_DATA_W'(es_detect_us));
      end
      SEG_WINDOW: begin
        seg_ctrl   = 1'b1;
        seg_enable = 1'b1;
        seg_hold   = at_least_one(es_window_us);
      end
      SEG_START: begin
        seg_ctrl = 1'b1;
        seg_hold = at_least_one(CFG_DATA_W'(start_us));
      end
      SEG_BIT_LO: begin
        seg_hold = bit_val ? hold_short : hold_long;
      end
      SEG_BIT_HI: begin
        seg_ctrl = 1'b1;
        seg_hold = bit_val ? hold_long : hold_short;
      end
      SEG_EOS: begin
        seg_hold = at_least_one(CFG_DATA_W'(eos_us));
      end
      SEG_FINAL: begin
        seg_ctrl = 1'b1;
        seg_hold = '0;
        seg_last = 1'b1;
      end
      default: ;
    endcase
  end

  // Request capture and line state tracking.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_zero  <= 1'b1;
      enabled    <= 1'b0;
      ctrl_now   <= 1'b0;
      enable_now <= 1'b0;
    end else if (cmd.emit) begin
      ctrl_now   <= seg_ctrl;
      enable_now <= seg_enable;
      if (cmd.seg == SEG_SHUT) begin
        enabled   <= 1'b0;
        prev_zero <= 1'b1;
      end else if (cmd.seg == SEG_FINAL) begin
        enabled   <= 1'b1;
        prev_zero <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      level <= level_in;
    end
  end

  // Output register: holds one segment until the consumer takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_ctrl   <= seg_ctrl;
      out_enable <= seg_enable;
      out_hold   <= seg_hold;
      out_last   <= seg_last;
    end
  end

  assign status.out_free   = !out_valid || out_ready;
  assign status.prev_zero  = prev_zero;
  assign status.level_zero = (level == '0);
  assign status.enabled    = enabled;

endmodule

// ----- hdl/one_wire_backlight_pulse_encoder_core.sv -----
// Top level of the one-wire backlight pulse encoder.
// Depends on owbpe_pkg, owbpe_ctrl and owbpe_datapath.
//
// Each accepted backlight level becomes a run of line segments on the master
// stream, one segment per cycle while the consumer keeps m_tready high. The run
// is an optional 200 ms wait after a shutdown or after reset, then either a
// shutdown segment or the enable preamble (when not yet enabled), the address
// frame, the data frame and a closing control-high segment with hold 0. The
// final segment of every run is marked by m_tlast. A run has 1 to 41 segments.
// A request occupies the block from the accept through each of its segments;
// when no wait segment is sent, the sequencer's first decision also holds it
// without emitting a segment. The single output register sets the
// pace, and a new level is taken only after the previous run has been fully
// handed to the output register. Configuration writes are taken at any time
// and must happen only while the block is idle.
module one_wire_backlight_pulse_encoder_core #(
  parameter int ADDR_BITS = owbpe_pkg::ADDR_BITS_DEF,
  parameter int DATA_BITS = owbpe_pkg::DATA_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // Configuration write channel.
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [owbpe_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [owbpe_pkg::CFG_DATA_W-1:0]     cfg_data,
  // Level requests.
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [owbpe_pkg::S_TDATA_W-1:0]      s_tdata,   // [7:0] level
  // Line segments.
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [owbpe_pkg::M_TDATA_W-1:0]      m_tdata,   // [0] ctrl_line, [1] enable_line,
                                                          // [19:2] hold_us, [23:20] zero
  output logic                                 m_tlast
);
  import owbpe_pkg::*;

  cmd_t              cmd;
  status_t           status;
  logic              out_ctrl;
  logic              out_enable;
  logic [HOLD_W-1:0] out_hold;

  owbpe_ctrl #(
    .ADDR_BITS (ADDR_BITS),
    .DATA_BITS (DATA_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  owbpe_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .level_in   (s_tdata[LEVEL_W-1:0]),
    .cmd        (cmd),
    .status     (status),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_ctrl   (out_ctrl),
    .out_enable (out_enable),
    .out_hold   (out_hold),
    .out_last   (m_tlast)
  );

  // Pack the segment fields, lowest field first.
  assign m_tdata = {(M_TDATA_W - HOLD_W - 2)'(0), out_hold, out_enable, out_ctrl};

endmodule
